// ----- hw/rtl/lqfl_pkg.sv -----
// Shared types and codes for the linked-list queue with free-list allocator.
`default_nettype none
package lqfl_pkg;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

endpackage
`default_nettype wire

// ----- hw/rtl/linked_queue_on_free_list.sv -----
// Byte FIFO kept as a linked list in a node store, with a free-list allocator.
//
// Usage:
//   A request (mode, data_in) is taken at a rising edge with start high and
//   busy low. mode 0 appends data_in; mode 1 removes the front element.
//   Each request gives one result: done is high for exactly one cycle with
//   status, data_out, is_empty and is_full valid in that same cycle.
//   done is registered from the S_EXEC state that follows the accepting edge.
//   No request is taken while busy; busy is high for the one cycle
//   in which the link read from the node store is applied and written back.
//   A new request may be taken in the cycle in which done is high.
//   The receiver cannot stall; results are not held beyond their cycle.
//   Reset: the queue is empty and every node is free. No clearing pass is
//   run; links of nodes never handed out are derived from a fill counter,
//   so the block takes requests in the first cycle after reset.
//   status: 0 done, 1 append dropped because no node is free,
//   2 removal from an empty queue. data_out is 0 unless a removal succeeds.
`default_nettype none
module linked_queue_on_free_list
    import lqfl_pkg::*;
#(
    parameter int NODE_COUNT = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       mode,
    input  wire logic [7:0] data_in,
    output logic            done,
    output logic [1:0]      status,
    output logic [7:0]      data_out,
    output logic            is_empty,
    output logic            is_full
);

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W = $clog2(NODE_COUNT + 1);

    logic [IDX_W:0] next_mem [NODE_COUNT];
    logic [7:0]     value_mem [NODE_COUNT];

    state_t         state_reg, state_next;
    logic           done_reg, done_next;

    logic             free_vld_reg, free_vld_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             qhead_vld_reg, qhead_vld_next;
    logic [IDX_W-1:0] qhead_idx_reg, qhead_idx_next;
    logic             qtail_vld_reg, qtail_vld_next;
    logic [IDX_W-1:0] qtail_idx_reg, qtail_idx_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;

    logic             op_mode_reg;
    logic [7:0]       op_data_reg;
    logic             op_ok_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             fresh_hit_reg;
    logic [IDX_W:0]   next_rd_reg;
    logic [7:0]       value_rd_reg;

    logic [1:0]       status_reg, status_next;
    logic [7:0]       data_out_reg, data_out_next;
    logic             is_empty_reg, is_empty_next;
    logic             is_full_reg, is_full_next;

    logic             accept;
    logic [IDX_W-1:0] rd_addr;
    logic             link_vld;
    logic [IDX_W-1:0] link_idx;
    logic             next_we;
    logic [IDX_W-1:0] next_wa;
    logic [IDX_W:0]   next_wd;
    logic             value_we;
    logic             exec;

    assign busy     = (state_reg == S_EXEC);
    assign accept   = start && !busy;
    assign exec     = (state_reg == S_EXEC);
    assign rd_addr  = (mode == MODE_DEQ) ? qhead_idx_reg : free_idx_reg;
    assign done     = done_reg;
    assign status   = status_reg;
    assign data_out = data_out_reg;
    assign is_empty = is_empty_reg;
    assign is_full  = is_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            free_vld_reg  <= 1'b1;
            free_idx_reg  <= IDX_W'(NODE_COUNT - 1);
            qhead_vld_reg <= 1'b0;
            qhead_idx_reg <= '0;
            qtail_vld_reg <= 1'b0;
            qtail_idx_reg <= '0;
            fresh_reg     <= CNT_W'(NODE_COUNT);
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            free_vld_reg  <= free_vld_next;
            free_idx_reg  <= free_idx_next;
            qhead_vld_reg <= qhead_vld_next;
            qhead_idx_reg <= qhead_idx_next;
            qtail_vld_reg <= qtail_vld_next;
            qtail_idx_reg <= qtail_idx_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Capture the request and read the node store.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg   <= mode;
            op_data_reg   <= data_in;
            op_ok_reg     <= (mode == MODE_DEQ) ? qhead_vld_reg : free_vld_reg;
            addr_reg      <= rd_addr;
            fresh_hit_reg <= CNT_W'(rd_addr) < fresh_reg;
            next_rd_reg   <= next_mem[rd_addr];
            value_rd_reg  <= value_mem[rd_addr];
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (value_we)
        begin
            value_mem[addr_reg] <= op_data_reg;
        end
        if (exec)
        begin
            status_reg   <= status_next;
            data_out_reg <= data_out_next;
            is_empty_reg <= is_empty_next;
            is_full_reg  <= is_full_next;
        end
    end

    // Derive links of untouched nodes from the fill counter.
    always_comb
    begin
        if (fresh_hit_reg)
        begin
            link_vld = (addr_reg != '0);
            link_idx = addr_reg - IDX_W'(1);
        end
        else
        begin
            link_vld = next_rd_reg[IDX_W];
            link_idx = next_rd_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        qhead_vld_next = qhead_vld_reg;
        qhead_idx_next = qhead_idx_reg;
        qtail_vld_next = qtail_vld_reg;
        qtail_idx_next = qtail_idx_reg;
        fresh_next     = fresh_reg;
        next_we        = 1'b0;
        next_wa        = addr_reg;
        next_wd        = {free_vld_reg, free_idx_reg};
        value_we       = 1'b0;
        status_next    = STAT_OK;
        data_out_next  = 8'd0;
        is_empty_next  = !qhead_vld_reg;
        is_full_next   = !free_vld_reg;
        if (exec)
        begin
            if (op_mode_reg == MODE_ENQ)
            begin
                if (op_ok_reg)
                begin
                    free_vld_next = link_vld;
                    free_idx_next = link_idx;
                    value_we      = 1'b1;
                    if (fresh_hit_reg)
                    begin
                        fresh_next = fresh_reg - CNT_W'(1);
                    end
                    if (qhead_vld_reg && qtail_vld_reg)
                    begin
                        next_we = 1'b1;
                        next_wa = qtail_idx_reg;
                        next_wd = {1'b1, addr_reg};
                    end
                    else
                    begin
                        qhead_vld_next = 1'b1;
                        qhead_idx_next = addr_reg;
                    end
                    qtail_vld_next = 1'b1;
                    qtail_idx_next = addr_reg;
                    is_empty_next  = 1'b0;
                    is_full_next   = !link_vld;
                end
                else
                begin
                    status_next  = STAT_FULL;
                    is_full_next = 1'b1;
                end
            end
            else
            begin
                if (op_ok_reg)
                begin
                    data_out_next = value_rd_reg;
                    next_we       = 1'b1;
                    free_vld_next = 1'b1;
                    free_idx_next = addr_reg;
                    is_full_next  = 1'b0;
                    if (addr_reg == qtail_idx_reg)
                    begin
                        qhead_vld_next = 1'b0;
                        qtail_vld_next = 1'b0;
                        is_empty_next  = 1'b1;
                    end
                    else
                    begin
                        qhead_idx_next = link_idx;
                        is_empty_next  = 1'b0;
                    end
                end
                else
                begin
                    status_next   = STAT_EMPTY;
                    is_empty_next = 1'b1;
                end
            end
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result without a request in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        qhead_vld_reg == qtail_vld_reg)
        else $error("queue head and tail disagree on emptiness");

    assert property (@(posedge clk) disable iff (!rst_n)
        !free_vld_reg |-> (fresh_reg == '0))
        else $error("free list empty while untouched nodes remain");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STAT_EMPTY) |-> is_empty && (data_out == 8'd0))
        else $error("empty removal reported inconsistently");
`endif

endmodule
`default_nettype wire

// ----- sim/lqfl_checker.sv -----
// Checker for the linked-list byte queue: predicts each request's result and compares.
module lqfl_checker
    import lqfl_pkg::*;
#(
    parameter int NODE_COUNT = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       mode,
    input  logic [7:0] data_in,
    input  logic       done,
    input  logic [1:0] status,
    input  logic [7:0] data_out,
    input  logic       is_empty,
    input  logic       is_full,
    output int         mismatches,
    output int         outstanding
);

    localparam int LINK_W = $clog2(NODE_COUNT) + 1;
    localparam logic [LINK_W-1:0] NO_NODE = '1;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data;
        logic       empty;
        logic       full;
    } outcome_t;

    logic [7:0]        node_byte [NODE_COUNT];
    logic [LINK_W-1:0] node_link [NODE_COUNT];
    logic [LINK_W-1:0] free_top;
    logic [LINK_W-1:0] front;
    logic [LINK_W-1:0] rear;
    outcome_t          awaited_outcomes [$];
    outcome_t          want;
    int                fail_tally = 0;
    int                in_flight = 0;

    assign mismatches  = fail_tally;
    assign outstanding = in_flight;

    function automatic logic is_node(logic [LINK_W-1:0] link);
        return link < NODE_COUNT;
    endfunction

    function automatic outcome_t apply_request(logic op, logic [7:0] byte_in);
        outcome_t          r;
        logic [LINK_W-1:0] n;
        r = '{STAT_OK, 8'h00, 1'b0, 1'b0};
        if (op == MODE_ENQ)
        begin
            n = free_top;
            if (!is_node(n))
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                free_top     = node_link[n];
                node_byte[n] = byte_in;
                node_link[n] = NO_NODE;
                if (!is_node(front) || !is_node(rear))
                begin
                    front = n;
                end
                else
                begin
                    node_link[rear] = n;
                end
                rear = n;
            end
        end
        else
        begin
            n = front;
            if (!is_node(n))
            begin
                r.status = STAT_EMPTY;
            end
            else
            begin
                r.data       = node_byte[n];
                front        = node_link[n];
                node_link[n] = free_top;
                free_top     = n;
            end
            if (!is_node(front))
            begin
                front = NO_NODE;
                rear  = NO_NODE;
            end
        end
        r.empty = !is_node(front);
        r.full  = !is_node(free_top);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int expected);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, expected, $realtime);
        fail_tally++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                node_byte[i] = 8'h00;
                node_link[i] = (i == 0) ? NO_NODE : LINK_W'(i - 1);
            end
            free_top = LINK_W'(NODE_COUNT - 1);
            front    = NO_NODE;
            rear     = NO_NODE;
            awaited_outcomes.delete();
            in_flight <= 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    report_mismatch("result with no request pending", 1, 0);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (data_out !== want.data)
                        report_mismatch("data_out", data_out, want.data);
                    if (is_empty !== want.empty)
                        report_mismatch("is_empty", is_empty, want.empty);
                    if (is_full !== want.full)
                        report_mismatch("is_full", is_full, want.full);
                end
            end
            if (start && !busy)
            begin
                awaited_outcomes.push_back(apply_request(mode, data_in));
            end
            in_flight <= awaited_outcomes.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the linked-list byte queue regression: reset, request stimulus, verdict.
module tb_top
    import lqfl_pkg::*;
();

    localparam int NODES           = 8;
    localparam int RANDOM_REQUESTS = 1030;
    localparam int IDLE_LIMIT      = 200;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       mode;
    logic [7:0] data_in;
    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [7:0] data_out;
    logic       is_empty;
    logic       is_full;

    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;
    logic no_idle = 1'b0;
    int   deq_percent = 50;
    int   run_left = 0;

    linked_queue_on_free_list #(
        .NODE_COUNT(NODES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .mode    (mode),
        .data_in (data_in),
        .done    (done),
        .status  (status),
        .data_out(data_out),
        .is_empty(is_empty),
        .is_full (is_full)
    );

    lqfl_checker #(
        .NODE_COUNT(NODES)
    ) i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .data_in    (data_in),
        .done       (done),
        .status     (status),
        .data_out   (data_out),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("linked_queue_on_free_list regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // hold the request until it is taken; lower start only across a gap
    task automatic send_request(logic op, logic [7:0] byte_in);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        mode    <= op;
        data_in <= byte_in;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        clk     = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        mode    = MODE_ENQ;
        data_in = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // fill the store to full, overflow, drain, underflow
        send_request(MODE_ENQ, 8'h00);
        send_request(MODE_ENQ, 8'hFF);
        send_request(MODE_ENQ, 8'hAA);
        send_request(MODE_ENQ, 8'h55);
        send_request(MODE_ENQ, 8'h01);
        send_request(MODE_ENQ, 8'h80);
        send_request(MODE_ENQ, 8'h7F);
        send_request(MODE_ENQ, 8'hFE);
        send_request(MODE_ENQ, 8'h3C);
        repeat (NODES) send_request(MODE_DEQ, 8'hFF);
        send_request(MODE_DEQ, 8'h00);
        // single element in and out, then underflow again
        send_request(MODE_ENQ, 8'h5A);
        send_request(MODE_DEQ, 8'hA5);
        send_request(MODE_DEQ, 8'h00);

        // drift between empty and full with biased bursts
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0: deq_percent = 20;
                    1: deq_percent = 50;
                    default: deq_percent = 80;
                endcase
            end
            run_left--;
            if ($urandom_range(0, 29) == 0)
                no_idle = !no_idle;
            send_request(($urandom_range(0, 99) < deq_percent) ? MODE_DEQ : MODE_ENQ,
                         8'($urandom_range(0, 255)));
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("linked_queue_on_free_list regression: pass");
        else
            $display("linked_queue_on_free_list regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lqfl_pkg.sv
hw/rtl/linked_queue_on_free_list.sv
sim/lqfl_checker.sv
sim/tb_top.sv
